### design/escaped_api_frame_receiver_core_macros.svh
// Assertion macros for the escaped API frame receiver.
// Included by the modules that carry concurrent assertions; no other dependencies.
`ifndef ESCAPED_API_FRAME_RECEIVER_CORE_MACROS_SVH
`define ESCAPED_API_FRAME_RECEIVER_CORE_MACROS_SVH

// Implication checked at every rising clock edge outside reset.
`define EFR_ASSERT(lbl, clk, rst_n, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Check that is also evaluated while reset is asserted.
`define EFR_ASSERT_ALWAYS(lbl, clk, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

### design/efr_pkg.sv
// Shared types and constants of the escaped API frame receiver.
// No dependencies; imported by every module of the block.
package efr_pkg;

  localparam logic [7:0] ESC_BYTE    = 8'h7D;
  localparam logic [7:0] ESC_XOR     = 8'h20;
  localparam logic [7:0] START_BYTE  = 8'h7E;
  localparam logic [7:0] TYPE_ZB_RX  = 8'h90;
  localparam logic [7:0] TYPE_IO_RX  = 8'h92;
  localparam logic [7:0] TYPE_AT_RSP = 8'h88;

  localparam logic [7:0] SUB_2 = 8'h02;
  localparam logic [7:0] SUB_4 = 8'h04;
  localparam logic [7:0] SUB_6 = 8'h06;
  localparam logic [7:0] SUB_8 = 8'h08;
  localparam logic [7:0] SUB_A = 8'h0A;

  localparam int unsigned QDepth = 2;

  typedef enum logic [1:0] {
    PH_IDLE,
    PH_LEN_HI,
    PH_LEN_LO,
    PH_BODY
  } efr_phase_e;

  typedef enum logic [3:0] {
    CLS_SUB_2,
    CLS_SUB_4,
    CLS_SUB_6,
    CLS_SUB_8,
    CLS_SUB_A,
    CLS_IO_RX,
    CLS_AT_RSP,
    CLS_UNK_TYPE,
    CLS_UNK_SUB,
    CLS_TOO_SHORT
  } efr_class_e;

  // One unescaped word as it travels from the front end to the parser.
  typedef struct packed {
    logic [7:0] data;
    logic       escaped;
  } efr_qent_t;

  // Queue status seen by both ends.
  typedef struct packed {
    logic full;
    logic empty;
  } efr_qstat_t;

endpackage

### design/efr_if.sv
// Valid/ready channel interfaces of the escaped API frame receiver.
// Depends on nothing; used by the top level and the front and back ends.
interface efr_rx_if;
  logic       valid;
  logic       ready;
  logic [7:0] rx_byte;

  modport source (output valid, output rx_byte, input ready);
  modport sink   (input valid, input rx_byte, output ready);
endinterface

interface efr_frame_if;
  logic        valid;
  logic        ready;
  logic [7:0]  frame_byte;
  logic [16:0] byte_index;
  logic        last_of_frame;
  logic [3:0]  frame_class;

  modport source (output valid, output frame_byte, output byte_index,
                  output last_of_frame, output frame_class, input ready);
  modport sink   (input valid, input frame_byte, input byte_index,
                  input last_of_frame, input frame_class, output ready);
endinterface

### design/efr_front.sv
// Front end: takes raw serial words, strips escapes and pushes data words.
// Depends on efr_pkg and efr_rx_if.
module efr_front import efr_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  efr_rx_if.sink      rx_i,
  input  efr_qstat_t  qstat_i,
  output logic        push_o,
  output efr_qent_t   push_data_o
);

  logic esc_q, esc_d;
  logic accept;

  assign rx_i.ready = !qstat_i.full;
  assign accept     = rx_i.valid && rx_i.ready;

  always_comb begin
    esc_d            = esc_q;
    push_o           = 1'b0;
    push_data_o.data    = rx_i.rx_byte;
    push_data_o.escaped = 1'b0;
    if (accept) begin
      if (esc_q) begin
        push_o              = 1'b1;
        push_data_o.data    = rx_i.rx_byte ^ ESC_XOR;
        push_data_o.escaped = 1'b1;
        esc_d               = 1'b0;
      end else if (rx_i.rx_byte == ESC_BYTE) begin
        esc_d = 1'b1;
      end else begin
        push_o = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      esc_q <= 1'b0;
    end else begin
      esc_q <= esc_d;
    end
  end

endmodule

### design/efr_fifo.sv
// Short queue that decouples the unescaping front end from the frame parser.
// Depends on efr_pkg and the assertion macro header.
`include "escaped_api_frame_receiver_core_macros.svh"

module efr_fifo import efr_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       push_i,
  input  efr_qent_t  push_data_i,
  input  logic       pop_i,
  output efr_qent_t  pop_data_o,
  output efr_qstat_t qstat_o
);

  localparam int unsigned PtrW = (QDepth > 1) ? $clog2(QDepth) : 1;
  localparam int unsigned CntW = $clog2(QDepth + 1);
  localparam logic [PtrW-1:0] LastPtr = PtrW'(QDepth - 1);
  localparam logic [CntW-1:0] FullCnt = CntW'(QDepth);

  efr_qent_t mem_q [QDepth];
  logic [PtrW-1:0] wr_ptr_q, rd_ptr_q;
  logic [CntW-1:0] cnt_q;
  logic do_push, do_pop;

  assign qstat_o.full  = (cnt_q == FullCnt);
  assign qstat_o.empty = (cnt_q == '0);
  assign do_push = push_i && !qstat_o.full;
  assign do_pop  = pop_i && !qstat_o.empty;
  assign pop_data_o = mem_q[rd_ptr_q];

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= push_data_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      if (do_push) begin
        wr_ptr_q <= (wr_ptr_q == LastPtr) ? '0 : wr_ptr_q + 1'b1;
      end
      if (do_pop) begin
        rd_ptr_q <= (rd_ptr_q == LastPtr) ? '0 : rd_ptr_q + 1'b1;
      end
      case ({do_push, do_pop})
        2'b10:   cnt_q <= cnt_q + 1'b1;
        2'b01:   cnt_q <= cnt_q - 1'b1;
        default: cnt_q <= cnt_q;
      endcase
    end
  end

  `EFR_ASSERT_ALWAYS(a_cnt_bound, clk_i, cnt_q <= FullCnt, "queue count above depth")
  `EFR_ASSERT(a_no_lost_push, clk_i, rst_ni, push_i |-> !qstat_o.full, "push into full queue")
  `EFR_ASSERT(a_cnt_step, clk_i, rst_ni, (push_i && !pop_i && !qstat_o.full) |=> (cnt_q == $past(cnt_q) + 1'b1), "queue count did not grow on push")

endmodule

### design/efr_back.sv
// Back end: parses unescaped words into frames and holds the result word.
// Depends on efr_pkg, efr_frame_if and the assertion macro header.
`include "escaped_api_frame_receiver_core_macros.svh"

module efr_back import efr_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  efr_qstat_t  qstat_i,
  input  efr_qent_t   pop_data_i,
  output logic        pop_o,
  efr_frame_if.source frame_o
);

  efr_phase_e  phase_q, phase_d;
  logic [15:0] len_q, len_d;
  logic [16:0] pos_q, pos_d;
  logic [7:0]  type_q, type_d;
  logic [7:0]  sub_q, sub_d;

  logic        ovalid_q, ovalid_d;
  logic [7:0]  obyte_q, obyte_d;
  logic [16:0] oidx_q, oidx_d;
  logic        olast_q, olast_d;
  efr_class_e  ocls_q, ocls_d;

  logic        emit;
  logic        load;
  logic [16:0] end_pos;
  logic [7:0]  b;

  function automatic efr_class_e classify(logic [15:0] len, logic [7:0] typ,
                                          logic [7:0] sub);
    efr_class_e c;
    c = CLS_UNK_TYPE;
    if (len == '0) begin
      c = CLS_TOO_SHORT;
    end else begin
      case (typ)
        TYPE_ZB_RX: begin
          if (len < 16'd13) begin
            c = CLS_TOO_SHORT;
          end else begin
            case (sub)
              SUB_2:   c = CLS_SUB_2;
              SUB_4:   c = CLS_SUB_4;
              SUB_6:   c = CLS_SUB_6;
              SUB_8:   c = CLS_SUB_8;
              SUB_A:   c = CLS_SUB_A;
              default: c = CLS_UNK_SUB;
            endcase
          end
        end
        TYPE_IO_RX:  c = CLS_IO_RX;
        TYPE_AT_RSP: c = CLS_AT_RSP;
        default:     c = CLS_UNK_TYPE;
      endcase
    end
    return c;
  endfunction

  assign b       = pop_data_i.data;
  assign end_pos = {1'b0, len_q} + 17'd3;
  assign pop_o   = !qstat_i.empty && (!ovalid_q || frame_o.ready);

  always_comb begin
    phase_d = phase_q;
    len_d   = len_q;
    pos_d   = pos_q;
    type_d  = type_q;
    sub_d   = sub_q;
    emit    = 1'b0;
    oidx_d  = pos_q;
    olast_d = 1'b0;
    ocls_d  = CLS_SUB_2;
    obyte_d = b;
    if (pop_o) begin
      unique case (phase_q)
        PH_IDLE: begin
          if (!pop_data_i.escaped && b == START_BYTE) begin
            emit    = 1'b1;
            oidx_d  = 17'd0;
            phase_d = PH_LEN_HI;
            pos_d   = 17'd1;
          end
        end
        PH_LEN_HI: begin
          emit    = 1'b1;
          oidx_d  = 17'd1;
          len_d   = {b, 8'h00};
          phase_d = PH_LEN_LO;
          pos_d   = 17'd2;
        end
        PH_LEN_LO: begin
          emit    = 1'b1;
          oidx_d  = 17'd2;
          len_d   = {len_q[15:8], b};
          phase_d = PH_BODY;
          pos_d   = 17'd3;
        end
        PH_BODY: begin
          emit   = 1'b1;
          oidx_d = pos_q;
          if (pos_q == 17'd3) begin
            type_d = b;
          end
          if (pos_q == 17'd15) begin
            sub_d = b;
          end
          if (pos_q >= end_pos) begin
            olast_d = 1'b1;
            ocls_d  = classify(len_q, type_d, sub_d);
            phase_d = PH_IDLE;
            pos_d   = 17'd0;
          end else begin
            pos_d = pos_q + 17'd1;
          end
        end
        default: phase_d = PH_IDLE;
      endcase
    end
  end

  assign load = pop_o && emit;

  always_comb begin
    ovalid_d = ovalid_q;
    if (load) begin
      ovalid_d = 1'b1;
    end else if (frame_o.ready) begin
      ovalid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q  <= PH_IDLE;
      len_q    <= '0;
      pos_q    <= '0;
      type_q   <= '0;
      sub_q    <= '0;
      ovalid_q <= 1'b0;
    end else begin
      phase_q  <= phase_d;
      len_q    <= len_d;
      pos_q    <= pos_d;
      type_q   <= type_d;
      sub_q    <= sub_d;
      ovalid_q <= ovalid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      obyte_q <= obyte_d;
      oidx_q  <= oidx_d;
      olast_q <= olast_d;
      ocls_q  <= ocls_d;
    end
  end

  assign frame_o.valid         = ovalid_q;
  assign frame_o.frame_byte    = obyte_q;
  assign frame_o.byte_index    = oidx_q;
  assign frame_o.last_of_frame = olast_q;
  assign frame_o.frame_class   = ocls_q;

  `EFR_ASSERT(a_last_idle, clk_i, rst_ni, (ovalid_q && olast_q) |-> (phase_q == PH_IDLE), "parser left idle while frame end is pending")
  `EFR_ASSERT(a_cls_zero, clk_i, rst_ni, (ovalid_q && !olast_q) |-> (ocls_q == CLS_SUB_2), "class set on a word that does not end a frame")
  `EFR_ASSERT(a_start_word, clk_i, rst_ni, (ovalid_q && oidx_q == 17'd0) |-> (obyte_q == START_BYTE), "position zero is not the start delimiter")

endmodule

### design/escaped_api_frame_receiver_core.sv
// An accepted word is written into the queue, then popped by the parser into its output register.
// Throughput: one raw word per cycle while the queue is not full; an escape word is consumed without a result.
// The rate is set by the two-entry queue and the single output register of the parser.
// Reset (rst_ni low, asynchronous): parser idle, no escape pending, queue and output empty.
// Frame length, position, type and sub-type registers clear to zero on reset.
//
// Top level of the escaped API frame receiver. Depends on efr_pkg, efr_if,
// efr_front, efr_fifo and efr_back.
module escaped_api_frame_receiver_core import efr_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  efr_rx_if.sink      rx_i,
  efr_frame_if.source frame_o
);

  // The front end handles escaping only: an escape word sets a pending flag and
  // is dropped, the word after it is XORed and tagged as escaped so that the
  // parser never mistakes it for a start delimiter.
  efr_qstat_t qstat;
  logic       push;
  efr_qent_t  push_data;
  logic       pop;
  efr_qent_t  pop_data;

  efr_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .rx_i        (rx_i),
    .qstat_i     (qstat),
    .push_o      (push),
    .push_data_o (push_data)
  );

  // The queue lets the front end keep taking words while the output is
  // stalled, and it holds the parser's input stable across a stall.
  efr_fifo u_fifo (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (push),
    .push_data_i (push_data),
    .pop_i       (pop),
    .pop_data_o  (pop_data),
    .qstat_o     (qstat)
  );

  // The parser walks each frame from delimiter to checksum, tags every word
  // with its position and attaches the class code to the checksum word.
  // Words seen while idle that are not a plain delimiter are discarded here.
  efr_back u_back (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .qstat_i    (qstat),
    .pop_data_i (pop_data),
    .pop_o      (pop),
    .frame_o    (frame_o)
  );

endmodule
